// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each check is clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/mvt_pkg.sv -----
package mvt_pkg;

  // Width of one vector component, signed Q16.16 at the default.
  localparam int unsigned COMPONENT_WIDTH = 32;

  // Configuration port: four row registers of 64 bits each.
  localparam int unsigned CFG_WIDTH     = 64;
  localparam int unsigned NUM_ROWS      = 4;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  // One input item: the vector to transform.
  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] in_x;
    logic signed [COMPONENT_WIDTH-1:0] in_y;
    logic signed [COMPONENT_WIDTH-1:0] in_z;
    logic signed [COMPONENT_WIDTH-1:0] in_w;
  } in_t;

  // One result item: the transformed vector and the clip flag.
  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] out_x;
    logic signed [COMPONENT_WIDTH-1:0] out_y;
    logic signed [COMPONENT_WIDTH-1:0] out_z;
    logic signed [COMPONENT_WIDTH-1:0] out_w;
    logic                              saturated;
  } out_t;

  // Picks the vector component that multiplies matrix column idx.
  function automatic logic signed [COMPONENT_WIDTH-1:0] comp_sel(in_t v,
                                                                 logic [1:0] idx);
    logic signed [COMPONENT_WIDTH-1:0] c;
    unique case (idx)
      2'd0: c = v.in_x;
      2'd1: c = v.in_y;
      2'd2: c = v.in_z;
      2'd3: c = v.in_w;
      default: c = v.in_x;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/mvt_mac_cell.sv -----
`include "assert_macros.svh"

module mvt_mac_cell #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned COL        = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       up_valid_i,
  output logic                                       up_ready_o,
  input  mvt_pkg::in_t                               up_vec_i,
  input  logic [3:0][mvt_pkg::COMPONENT_WIDTH+COEF_WIDTH+1:0] up_sum_i,
  input  logic [3:0][COEF_WIDTH-1:0]                 coef_i,
  output logic                                       dn_valid_o,
  input  logic                                       dn_ready_i,
  output mvt_pkg::in_t                               dn_vec_o,
  output logic [3:0][mvt_pkg::COMPONENT_WIDTH+COEF_WIDTH+1:0] dn_sum_o
);
  import mvt_pkg::*;

  localparam int unsigned PROD_W = COMPONENT_WIDTH + COEF_WIDTH;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic                               valid_q;
  in_t                                vec_q;
  logic [3:0][SUM_W-1:0]              sum_q;
  logic [3:0][SUM_W-1:0]              sum_d;
  logic signed [COMPONENT_WIDTH-1:0]  comp;
  logic signed [PROD_W-1:0]           prod [4];
  logic                               load;

  // The stage takes a new item when it is empty or its item moves on.
  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;

  // Each row adds this column's product to the partial dot product.
  always_comb begin
    comp = comp_sel(up_vec_i, 2'(COL));
    for (int r = 0; r < 4; r++) begin
      prod[r]  = PROD_W'($signed(coef_i[r])) * PROD_W'(comp);
      sum_d[r] = up_sum_i[r] + SUM_W'(prod[r]);
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      vec_q <= up_vec_i;
      sum_q <= sum_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_vec_o   = vec_q;
  assign dn_sum_o   = sum_q;

  // A held item keeps its partial sums until the next cell takes it.
  `ASSERT_NEXT(a_cell_hold, clk_i, rst_ni, valid_q && !dn_ready_i, valid_q && $stable(sum_q))

endmodule

// ----- sv/mvt_round.sv -----
`include "assert_macros.svh"

module mvt_round #(
  parameter int unsigned COEF_WIDTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       up_valid_i,
  output logic                                       up_ready_o,
  input  logic [3:0][mvt_pkg::COMPONENT_WIDTH+COEF_WIDTH+1:0] up_sum_i,
  output logic                                       dn_valid_o,
  input  logic                                       dn_ready_i,
  output mvt_pkg::out_t                              dn_data_o
);
  import mvt_pkg::*;

  localparam int unsigned SUM_W = COMPONENT_WIDTH + COEF_WIDTH + 2;
  localparam int unsigned FRAC  = COEF_WIDTH - 4;
  localparam int unsigned EXT_W = SUM_W + 1;
  localparam int unsigned SH_W  = EXT_W - FRAC;
  localparam int unsigned TOP_W = SH_W - COMPONENT_WIDTH + 1;

  localparam logic signed [COMPONENT_WIDTH-1:0] MAX_VAL = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic signed [COMPONENT_WIDTH-1:0] MIN_VAL = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
  localparam logic [EXT_W-1:0]                  HALF    = EXT_W'(1) << (FRAC - 1);

  logic                              valid_q;
  out_t                              data_q;
  out_t                              data_d;
  logic signed [EXT_W-1:0]           biased  [4];
  logic signed [SH_W-1:0]            shifted [4];
  logic [TOP_W-1:0]                  top_bits[4];
  logic [3:0]                        clip;
  logic signed [COMPONENT_WIDTH-1:0] res     [4];

  assign up_ready_o = !valid_q || dn_ready_i;

  // Round half up, drop the coefficient fraction, then clip to the component range.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      biased[r]   = $signed({up_sum_i[r][SUM_W-1], up_sum_i[r]}) + $signed(HALF);
      shifted[r]  = SH_W'(biased[r] >>> FRAC);
      top_bits[r] = shifted[r][SH_W-1:COMPONENT_WIDTH-1];
      clip[r]     = !((&top_bits[r]) || !(|top_bits[r]));
      if (clip[r]) begin
        res[r] = shifted[r][SH_W-1] ? MIN_VAL : MAX_VAL;
      end else begin
        res[r] = shifted[r][COMPONENT_WIDTH-1:0];
      end
    end
    data_d.out_x     = res[0];
    data_d.out_y     = res[1];
    data_d.out_z     = res[2];
    data_d.out_w     = res[3];
    data_d.saturated = |clip;
  end

  // Output register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  // A raised clip flag means at least one component sits at a range end.
  `ASSERT_SAME(a_sat_extreme, clk_i, rst_ni, valid_q && data_q.saturated, (data_q.out_x == MAX_VAL) || (data_q.out_x == MIN_VAL) || (data_q.out_y == MAX_VAL) || (data_q.out_y == MIN_VAL) || (data_q.out_z == MAX_VAL) || (data_q.out_z == MIN_VAL) || (data_q.out_w == MAX_VAL) || (data_q.out_w == MIN_VAL))

endmodule

// ----- sv/matrix_vector_transform_4x4.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   in_data_i  (x, y, z, w)
// output    out        out_valid_o / out_stall_i out_data_o (x, y, z, w, saturated)
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle while input is not stalled; each result passes
// through four multiply-accumulate cells, one per matrix column, then the
// rounding and clipping register.
// Reset clears every stage and loads the identity matrix.
// A stalled output holds the pipeline; empty stages still fill, so input is
// stalled only when all five stages hold an item and the output is stalled.
`include "assert_macros.svh"

module matrix_vector_transform_4x4 #(
  parameter int unsigned COEF_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mvt_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mvt_pkg::out_t                        out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [mvt_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [mvt_pkg::CFG_WIDTH-1:0]        cfg_data_i
);
  import mvt_pkg::*;

  localparam int unsigned SUM_W   = COMPONENT_WIDTH + COEF_WIDTH + 2;
  localparam int unsigned ROW_W   = 4 * COEF_WIDTH;
  localparam int unsigned ONE_POS = COEF_WIDTH - 4;

  logic [NUM_ROWS-1:0][ROW_W-1:0]      rows_q;
  logic [3:0][3:0][COEF_WIDTH-1:0]     coef_col;
  logic [4:0]                          stage_valid;
  logic [4:0]                          stage_ready;
  in_t                                 stage_vec [4];
  logic [3:0][SUM_W-1:0]               stage_sum [5];

  // Matrix rows; a write replaces one whole row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_q[r] <= ROW_W'(1) << (ONE_POS + r * COEF_WIDTH);
      end
    end else if (cfg_we_i) begin
      rows_q[cfg_idx_i] <= cfg_data_i[ROW_W-1:0];
    end
  end

  // Regroup the coefficients by column, one column per cell.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        coef_col[c][r] = rows_q[r][c*COEF_WIDTH +: COEF_WIDTH];
      end
    end
  end

  // Head of the chain.
  assign stage_valid[0] = in_valid_i;
  assign in_stall_o     = !stage_ready[0];
  assign stage_vec[0]   = in_data_i;
  assign stage_sum[0]   = '0;

  // Chain of multiply-accumulate cells, one per matrix column.
  for (genvar c = 0; c < 4; c++) begin : g_cell
    if (c < 3) begin : g_mid
      mvt_mac_cell #(
        .COEF_WIDTH(COEF_WIDTH),
        .COL       (c)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .up_valid_i(stage_valid[c]),
        .up_ready_o(stage_ready[c]),
        .up_vec_i  (stage_vec[c]),
        .up_sum_i  (stage_sum[c]),
        .coef_i    (coef_col[c]),
        .dn_valid_o(stage_valid[c+1]),
        .dn_ready_i(stage_ready[c+1]),
        .dn_vec_o  (stage_vec[c+1]),
        .dn_sum_o  (stage_sum[c+1])
      );
    end else begin : g_last
      mvt_mac_cell #(
        .COEF_WIDTH(COEF_WIDTH),
        .COL       (c)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .up_valid_i(stage_valid[c]),
        .up_ready_o(stage_ready[c]),
        .up_vec_i  (stage_vec[c]),
        .up_sum_i  (stage_sum[c]),
        .coef_i    (coef_col[c]),
        .dn_valid_o(stage_valid[c+1]),
        .dn_ready_i(stage_ready[c+1]),
        .dn_vec_o  (),
        .dn_sum_o  (stage_sum[c+1])
      );
    end
  end

  // Rounding, clipping and the output register.
  mvt_round #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .up_valid_i(stage_valid[4]),
    .up_ready_o(stage_ready[4]),
    .up_sum_i  (stage_sum[4]),
    .dn_valid_o(out_valid_o),
    .dn_ready_i(!out_stall_i),
    .dn_data_o (out_data_o)
  );

  // Input backs up only when the whole chain is full behind a stalled result.
  `ASSERT_SAME(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i && (&stage_valid[4:1]))

endmodule
